>>> hw/rtl/vf_open_loop_drive_step_core_defines.svh
// assertion macros for the open-loop drive step checker
`ifndef VF_OPEN_LOOP_DRIVE_STEP_CORE_DEFINES_SVH
`define VF_OPEN_LOOP_DRIVE_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define VFOLS_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vfols check failed");

// next-cycle implication
`define VFOLS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vfols check failed");

`endif

>>> hw/rtl/vfols_pkg.sv
// shared constants, rounding and saturation helpers of the open-loop drive step
package vfols_pkg;

   localparam int OPA_W  = 32;
   localparam int OPB_W  = 25;
   localparam int PROD_W = OPA_W + OPB_W;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_RATED_FREQ    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_PER_HZ  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATED_VOLTAGE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RPM_PER_HZ    = 8'd3;

   localparam logic [13:0] RST_RATED_FREQ    = 14'd960;
   localparam logic [23:0] RST_PHASE_PER_HZ  = 24'd429497;
   localparam logic [15:0] RST_RATED_VOLTAGE = 16'd32767;
   localparam logic [15:0] RST_RPM_PER_HZ    = 16'd7680;

   localparam logic signed [14:0] ONE_Q12 = 15'sd4096;
   localparam logic [15:0] TRIG_ONE       = 16'd16384;
   localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
   localparam logic [15:0] MAG_MAX        = 16'hFFFF;

   localparam logic [30:0] SIN_C1 = 31'd1686629713;
   localparam logic [30:0] SIN_C3 = 31'd693598668;
   localparam logic [30:0] SIN_C5 = 31'd85569306;
   localparam logic [30:0] SIN_C7 = 31'd5026995;

   localparam int DIVIDEND_W = 29;
   localparam int DIVISOR_W  = 14;
   localparam int QUOT_W     = 16;

   // round half away from zero on the magnitude, then restore the sign
   function automatic logic signed [PROD_W:0] rnd_shift(input logic signed [PROD_W:0] v,
                                                         input int unsigned sh);
      logic             neg;
      logic [PROD_W:0]  m;
      neg = v[PROD_W];
      m   = neg ? unsigned'(-v) : unsigned'(v);
      m   = (m + ((PROD_W+1)'(1) << (sh - 1))) >> sh;
      return neg ? -signed'(m) : signed'(m);
   endfunction

   function automatic logic signed [16:0] sat17(input logic signed [PROD_W:0] v);
      if (v < -(PROD_W+1)'(65536))
         return -17'sd65536;
      else if (v > (PROD_W+1)'(65535))
         return 17'sd65535;
      else
         return 17'(v);
   endfunction

endpackage

>>> hw/rtl/vfols_req_if.sv
// input item channel of the drive step
interface vfols_req_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] speed_ref;
   logic signed [15:0] cur_alpha;
   logic signed [15:0] cur_beta;
   logic signed [15:0] volt_alpha;
   logic signed [15:0] volt_beta;

   modport source (output valid, speed_ref, cur_alpha, cur_beta, volt_alpha, volt_beta,
                   input ready);
   modport sink   (input valid, speed_ref, cur_alpha, cur_beta, volt_alpha, volt_beta,
                   output ready);
endinterface

>>> hw/rtl/vfols_rsp_if.sv
// result item channel of the drive step
interface vfols_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] out_freq;
   logic signed [31:0] shaft_rpm;
   logic        [15:0] volt_mag;
   logic signed [16:0] volt_cmd_d;
   logic signed [16:0] volt_cmd_q;
   logic signed [16:0] cur_rot_d;
   logic signed [16:0] cur_rot_q;
   logic signed [16:0] volt_rot_d;
   logic signed [16:0] volt_rot_q;

   modport source (output valid, out_freq, shaft_rpm, volt_mag, volt_cmd_d, volt_cmd_q,
                   cur_rot_d, cur_rot_q, volt_rot_d, volt_rot_q, input ready);
   modport sink   (input valid, out_freq, shaft_rpm, volt_mag, volt_cmd_d, volt_cmd_q,
                   cur_rot_d, cur_rot_q, volt_rot_d, volt_rot_q, output ready);
endinterface

>>> hw/rtl/vfols_csr_if.sv
// register write channel of the drive step
interface vfols_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/vf_open_loop_drive_step_core.sv
// Open-loop V/f drive step: one item in, one result out, through a shared multiplier.
// Each of 24 multiplies passes through ST_MUL and ST_WB, then ST_FIN loads the result;
// above unit reference the magnitude comes from a 16-step divider (ST_DIV) instead.
// A new item is taken only in ST_IDLE, after the last result is loaded; waits for a held result.
// Reset (synchronous) restores register defaults, clears phase and drops rsp valid.
module vf_open_loop_drive_step_core #(
   parameter int TRIG_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   vfols_req_if.sink   req_chan,
   vfols_rsp_if.source rsp_chan,
   vfols_csr_if.sink   csr_chan
);
   import vfols_pkg::*;

   localparam int TRIG_SHIFT = 32 - TRIG_BITS;
   localparam logic [31:0] TRIG_MASK = ~((32'(1) << TRIG_SHIFT) - 32'(1));

   typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_WB, ST_DIV, ST_FIN} state_type;
   typedef enum logic [4:0] {
      OP_FREQ, OP_RPM, OP_DELTA, OP_Z2, OP_P5, OP_P3, OP_P1, OP_S, OP_MAG,
      OP_VD, OP_VQ, OP_CD1, OP_CD2, OP_CQ1, OP_CQ2, OP_RD1, OP_RD2, OP_RQ1, OP_RQ2
   } op_type;

   state_type state_ff;
   op_type    op_ff;

   logic [13:0] rated_freq_ff;
   logic [23:0] phase_per_hz_ff;
   logic [15:0] rated_voltage_ff;
   logic [15:0] rpm_per_hz_ff;
   logic [31:0] phase_ff;

   logic signed [14:0] ref_ff;
   logic signed [15:0] ia_ff, ib_ff, va_ff, vb_ff;
   logic signed [16:0] freq_ff;
   logic signed [31:0] rpm_ff;
   logic        [15:0] mag_ff;
   logic signed [16:0] vcd_ff, vcq_ff, crd_ff, crq_ff, vrd_ff, vrq_ff;
   logic        [16:0] z2_ff;
   logic        [30:0] p_ff;
   logic signed [15:0] sin_ff, cos_ff;
   logic               trig_sel_ff;
   logic signed [PROD_W-1:0] hold_ff;
   logic               div_start_ff;

   logic               rsp_valid_ff;
   logic signed [16:0] o_freq_ff, o_vcd_ff, o_vcq_ff, o_crd_ff, o_crq_ff, o_vrd_ff, o_vrq_ff;
   logic signed [31:0] o_rpm_ff;
   logic        [15:0] o_mag_ff;

   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W:0]   prod_x;
   logic signed [PROD_W:0]   rot_sum_in;
   logic signed [PROD_W:0]   rot_dif_in;
   logic signed [PROD_W:0]   rnd12_in, rnd14_in;
   logic        [PROD_W-1:0] prod_u;
   logic        [16:0]       fmag_in;
   logic        [14:0]       aref_in;
   logic                     div_case_in;
   logic        [31:0]       ph_trig_in;
   logic        [30:0]       r_in;
   logic        [16:0]       z_in;
   logic        [31:0]       delta_sum_in;
   logic        [31:0]       delta_in;
   logic        [31:0]       s_sum_in;
   logic        [15:0]       s_mag_in;
   logic signed [15:0]       s_val_in;
   logic        [DIVIDEND_W-1:0] dividend_in;
   logic                     div_done;
   logic        [QUOT_W-1:0] quotient;

   // trig argument: truncated phase, plus a quarter turn for cosine, folded into a quadrant
   assign ph_trig_in = (phase_ff & TRIG_MASK) + (trig_sel_ff ? QUARTER_TURN : 32'd0);
   assign r_in = ph_trig_in[30] ? (31'h4000_0000 - {1'b0, ph_trig_in[29:0]})
                                : {1'b0, ph_trig_in[29:0]};
   assign z_in = r_in[30:14];

   assign fmag_in     = freq_ff[16] ? unsigned'(-freq_ff) : unsigned'(freq_ff);
   assign aref_in     = ref_ff[14] ? unsigned'(-ref_ff) : unsigned'(ref_ff);
   assign div_case_in = ref_ff > ONE_Q12;
   assign dividend_in = {1'b0, rated_voltage_ff, 12'd0} + DIVIDEND_W'(unsigned'(ref_ff) >> 1);

   assign prod_x     = (PROD_W+1)'(prod);
   assign prod_u     = unsigned'(prod);
   assign rot_sum_in = (PROD_W+1)'(hold_ff) + prod_x;
   assign rot_dif_in = (PROD_W+1)'(hold_ff) - prod_x;
   assign rnd12_in   = rnd_shift(prod_x, 12);
   assign rnd14_in   = rnd_shift(prod_x, 14);

   assign delta_sum_in = prod_u[35:4] + {31'd0, prod_u[3]};
   assign delta_in     = delta_sum_in;

   assign s_sum_in = {1'b0, prod_u[46:16]} + 32'h0000_8000;
   assign s_mag_in = (s_sum_in[31:16] > TRIG_ONE) ? TRIG_ONE : s_sum_in[31:16];
   assign s_val_in = ph_trig_in[31] ? -signed'(s_mag_in) : signed'(s_mag_in);

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (op_ff)
         OP_FREQ:  begin op_a = OPA_W'(ref_ff);          op_b = OPB_W'(rated_freq_ff);    end
         OP_RPM:   begin op_a = OPA_W'(freq_ff);         op_b = OPB_W'(rpm_per_hz_ff);    end
         OP_DELTA: begin op_a = OPA_W'(fmag_in);         op_b = OPB_W'(phase_per_hz_ff);  end
         OP_Z2:    begin op_a = OPA_W'(z_in);            op_b = OPB_W'(z_in);             end
         OP_P5:    begin op_a = OPA_W'(SIN_C7);          op_b = OPB_W'(z2_ff);            end
         OP_P3:    begin op_a = OPA_W'(p_ff);            op_b = OPB_W'(z2_ff);            end
         OP_P1:    begin op_a = OPA_W'(p_ff);            op_b = OPB_W'(z2_ff);            end
         OP_S:     begin op_a = OPA_W'(p_ff);            op_b = OPB_W'(z_in);             end
         OP_MAG:   begin op_a = OPA_W'(aref_in);         op_b = OPB_W'(rated_voltage_ff); end
         OP_VD:    begin op_a = OPA_W'(mag_ff);          op_b = OPB_W'(cos_ff);           end
         OP_VQ:    begin op_a = OPA_W'(mag_ff);          op_b = OPB_W'(sin_ff);           end
         OP_CD1:   begin op_a = OPA_W'(cos_ff);          op_b = OPB_W'(ia_ff);            end
         OP_CD2:   begin op_a = OPA_W'(sin_ff);          op_b = OPB_W'(ib_ff);            end
         OP_CQ1:   begin op_a = OPA_W'(cos_ff);          op_b = OPB_W'(ib_ff);            end
         OP_CQ2:   begin op_a = OPA_W'(sin_ff);          op_b = OPB_W'(ia_ff);            end
         OP_RD1:   begin op_a = OPA_W'(cos_ff);          op_b = OPB_W'(va_ff);            end
         OP_RD2:   begin op_a = OPA_W'(sin_ff);          op_b = OPB_W'(vb_ff);            end
         OP_RQ1:   begin op_a = OPA_W'(cos_ff);          op_b = OPB_W'(vb_ff);            end
         OP_RQ2:   begin op_a = OPA_W'(sin_ff);          op_b = OPB_W'(va_ff);            end
         default:  begin op_a = '0;                      op_b = '0;                       end
      endcase
   end

   vfols_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   vfols_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dividend_in),
      .divisor  (unsigned'(ref_ff[13:0])),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         op_ff            <= OP_FREQ;
         rsp_valid_ff     <= 1'b0;
         div_start_ff     <= 1'b0;
         trig_sel_ff      <= 1'b0;
         phase_ff         <= '0;
         rated_freq_ff    <= RST_RATED_FREQ;
         phase_per_hz_ff  <= RST_PHASE_PER_HZ;
         rated_voltage_ff <= RST_RATED_VOLTAGE;
         rpm_per_hz_ff    <= RST_RPM_PER_HZ;
      end else begin
         div_start_ff <= 1'b0;

         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               REG_RATED_FREQ:    rated_freq_ff    <= csr_chan.data[13:0];
               REG_PHASE_PER_HZ:  phase_per_hz_ff  <= csr_chan.data[23:0];
               REG_RATED_VOLTAGE: rated_voltage_ff <= csr_chan.data[15:0];
               REG_RPM_PER_HZ:    rpm_per_hz_ff    <= csr_chan.data[15:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_chan.ready)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  ref_ff      <= req_chan.speed_ref;
                  ia_ff       <= req_chan.cur_alpha;
                  ib_ff       <= req_chan.cur_beta;
                  va_ff       <= req_chan.volt_alpha;
                  vb_ff       <= req_chan.volt_beta;
                  op_ff       <= OP_FREQ;
                  trig_sel_ff <= 1'b0;
                  state_ff    <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (op_ff == OP_MAG && div_case_in) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end else begin
                  state_ff <= ST_WB;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  mag_ff   <= quotient;
                  op_ff    <= OP_VD;
                  state_ff <= ST_MUL;
               end
            end
            ST_WB: begin
               state_ff <= ST_MUL;
               unique case (op_ff)
                  OP_FREQ: begin
                     freq_ff <= 17'(rnd12_in);
                     op_ff   <= OP_RPM;
                  end
                  OP_RPM: begin
                     rpm_ff <= 32'(rnd_shift(prod_x, 4));
                     op_ff  <= OP_DELTA;
                  end
                  OP_DELTA: begin
                     phase_ff <= freq_ff[16] ? phase_ff - delta_in : phase_ff + delta_in;
                     op_ff    <= OP_Z2;
                  end
                  OP_Z2: begin
                     z2_ff <= prod_u[32:16];
                     op_ff <= OP_P5;
                  end
                  OP_P5: begin
                     p_ff  <= 31'({1'b0, SIN_C5} - prod_u[47:16]);
                     op_ff <= OP_P3;
                  end
                  OP_P3: begin
                     p_ff  <= 31'({1'b0, SIN_C3} - prod_u[47:16]);
                     op_ff <= OP_P1;
                  end
                  OP_P1: begin
                     p_ff  <= 31'({1'b0, SIN_C1} - prod_u[47:16]);
                     op_ff <= OP_S;
                  end
                  OP_S: begin
                     // sine first, then the same unit again for cosine
                     if (trig_sel_ff) begin
                        cos_ff <= s_val_in;
                        op_ff  <= OP_MAG;
                     end else begin
                        sin_ff      <= s_val_in;
                        trig_sel_ff <= 1'b1;
                        op_ff       <= OP_Z2;
                     end
                  end
                  OP_MAG: begin
                     mag_ff <= (rnd12_in > (PROD_W+1)'(65535)) ? MAG_MAX : 16'(rnd12_in);
                     op_ff  <= OP_VD;
                  end
                  OP_VD: begin
                     vcd_ff <= 17'(rnd14_in);
                     op_ff  <= OP_VQ;
                  end
                  OP_VQ: begin
                     vcq_ff <= 17'(rnd14_in);
                     op_ff  <= OP_CD1;
                  end
                  OP_CD1: begin
                     hold_ff <= prod;
                     op_ff   <= OP_CD2;
                  end
                  OP_CD2: begin
                     crd_ff <= sat17(rnd_shift(rot_sum_in, 14));
                     op_ff  <= OP_CQ1;
                  end
                  OP_CQ1: begin
                     hold_ff <= prod;
                     op_ff   <= OP_CQ2;
                  end
                  OP_CQ2: begin
                     crq_ff <= sat17(rnd_shift(rot_dif_in, 14));
                     op_ff  <= OP_RD1;
                  end
                  OP_RD1: begin
                     hold_ff <= prod;
                     op_ff   <= OP_RD2;
                  end
                  OP_RD2: begin
                     vrd_ff <= sat17(rnd_shift(rot_sum_in, 14));
                     op_ff  <= OP_RQ1;
                  end
                  OP_RQ1: begin
                     hold_ff <= prod;
                     op_ff   <= OP_RQ2;
                  end
                  OP_RQ2: begin
                     vrq_ff   <= sat17(rnd_shift(rot_dif_in, 14));
                     state_ff <= ST_FIN;
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_FIN: begin
               // hold here only while the previous result is still unclaimed
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  o_freq_ff    <= freq_ff;
                  o_rpm_ff     <= rpm_ff;
                  o_mag_ff     <= mag_ff;
                  o_vcd_ff     <= vcd_ff;
                  o_vcq_ff     <= vcq_ff;
                  o_crd_ff     <= crd_ff;
                  o_crq_ff     <= crq_ff;
                  o_vrd_ff     <= vrd_ff;
                  o_vrq_ff     <= vrq_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_freq   = o_freq_ff;
   assign rsp_chan.shaft_rpm  = o_rpm_ff;
   assign rsp_chan.volt_mag   = o_mag_ff;
   assign rsp_chan.volt_cmd_d = o_vcd_ff;
   assign rsp_chan.volt_cmd_q = o_vcq_ff;
   assign rsp_chan.cur_rot_d  = o_crd_ff;
   assign rsp_chan.cur_rot_q  = o_crq_ff;
   assign rsp_chan.volt_rot_d = o_vrd_ff;
   assign rsp_chan.volt_rot_q = o_vrq_ff;
endmodule

>>> hw/rtl/vfols_mul.sv
// shared signed multiplier with registered product
module vfols_mul (
   input  logic                               clock,
   input  logic signed [vfols_pkg::OPA_W-1:0]  op_a,
   input  logic signed [vfols_pkg::OPB_W-1:0]  op_b,
   output logic signed [vfols_pkg::PROD_W-1:0] prod
);
   import vfols_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

>>> hw/rtl/vfols_div.sv
// restoring divider, one quotient bit per cycle
module vfols_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [vfols_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [vfols_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                 done,
   output logic [vfols_pkg::QUOT_W-1:0]         quotient
);
   import vfols_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [QUOT_W-1:0]    num_ff;
   logic [QUOT_W-1:0]    quot_ff;
   logic [DIVISOR_W:0]   trial_in;
   logic                 ge_in;

   assign trial_in = {rem_ff, num_ff[QUOT_W-1]};
   assign ge_in    = trial_in >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // quotient fits in QUOT_W bits, so the upper dividend bits are below divisor
            rem_ff  <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
            num_ff  <= dividend[QUOT_W-1:0];
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= ge_in ? DIVISOR_W'(trial_in - {1'b0, divisor}) : trial_in[DIVISOR_W-1:0];
            quot_ff <= {quot_ff[QUOT_W-2:0], ge_in};
            num_ff  <= {num_ff[QUOT_W-2:0], 1'b0};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

>>> hw/rtl/vfols_chk.sv
// port-level checker for the drive step, bound to the top level
`include "vf_open_loop_drive_step_core_defines.svh"

module vfols_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic        [15:0] volt_mag,
   input logic signed [16:0] volt_cmd_d,
   input logic signed [16:0] out_freq
);
   logic signed [17:0] mag_s;
   logic signed [17:0] cmd_s;

   assign mag_s = $signed({2'b00, volt_mag});
   assign cmd_s = 18'(volt_cmd_d);

   // sequencer drops ready once it has taken an item
   `VFOLS_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // no result can appear right after an item when none was pending
   `VFOLS_NEXT(a_no_early_rsp, req_valid && req_ready && !rsp_valid, !rsp_valid)
   // stalled result holds
   `VFOLS_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_freq))
   // rotating command never exceeds its magnitude
   `VFOLS_SAME(a_cmd_bound, rsp_valid, (cmd_s <= mag_s) && (cmd_s >= -mag_s))
endmodule

bind vf_open_loop_drive_step_core vfols_chk u_vfols_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .volt_mag   (rsp_chan.volt_mag),
   .volt_cmd_d (rsp_chan.volt_cmd_d),
   .out_freq   (rsp_chan.out_freq)
);
